/* hdl/tpt_pkg.sv */
// shared types and constants for the two-level page table engine
`default_nettype none

package tpt_pkg;

  // default sizing
  localparam int DIR_ENTRIES_DEF   = 1024;
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int TABLE_POOL_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // virtual address layout
  localparam int SLOT_LSB   = 22;
  localparam int PAGE_BITS  = 12;
  localparam int INDEX_W    = 10;
  localparam int FRAME_W    = 20;
  localparam int SLOT_CMP_W = INDEX_W + 1;

  // entry flag bits
  localparam logic [PAGE_BITS-1:0] ENTRY_PRESENT  = 12'h001;
  localparam logic [PAGE_BITS-1:0] ENTRY_IDENTITY = 12'h003;

  // command codes
  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_XLATE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // status codes
  typedef enum logic [1:0] {
    STAT_DONE       = 2'd0,
    STAT_NOT_MAPPED = 2'd1,
    STAT_NO_TABLE   = 2'd2,
    STAT_SPARE      = 2'd3
  } status_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIR,
    ST_CLEAR,
    ST_FILL,
    ST_READ
  } state_t;

  // classified request between front and back
  typedef struct packed {
    cmd_t                 cmd;
    logic [INDEX_W-1:0]   slot;
    logic [INDEX_W-1:0]   idx;
    logic [PAGE_BITS-1:0] offset;
    logic [FRAME_W-1:0]   frame;
    logic [PAGE_BITS-1:0] flags;
    logic                 slot_oob;
    logic                 idx_oob;
  } item_t;

  // one result
  typedef struct packed {
    logic [31:0] phys;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

/* hdl/tpt_fifo.sv */
// small register queue used between front, back and result port
`default_nettype none

module tpt_fifo #(
  parameter int WIDTH = $bits(tpt_pkg::item_t),
  parameter int DEPTH = tpt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0]   LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             wr_ok;
  logic             rd_ok;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_ok && !rd_ok) begin
        count <= count + 1'b1;
      end else if (rd_ok && !wr_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/tpt_front.sv */
// front end: splits the virtual address and range checks each request
`default_nettype none

module tpt_front #(
  parameter int DIR_ENTRIES   = tpt_pkg::DIR_ENTRIES_DEF,
  parameter int TABLE_ENTRIES = tpt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic [1:0]   cmd,
  input  wire logic [31:0]  virt_addr,
  input  wire logic [31:0]  phys_addr,
  input  wire logic [11:0]  page_flags,
  output tpt_pkg::item_t    item
);

  localparam logic [tpt_pkg::SLOT_CMP_W-1:0] DIR_LIM = tpt_pkg::SLOT_CMP_W'(DIR_ENTRIES);
  localparam logic [tpt_pkg::SLOT_CMP_W-1:0] TBL_LIM = tpt_pkg::SLOT_CMP_W'(TABLE_ENTRIES);

  logic [tpt_pkg::INDEX_W-1:0] slot;
  logic [tpt_pkg::INDEX_W-1:0] idx;

  assign slot = virt_addr[31:tpt_pkg::SLOT_LSB];
  assign idx  = virt_addr[tpt_pkg::SLOT_LSB-1:tpt_pkg::PAGE_BITS];

  // field split and out-of-range classification
  always_comb begin
    item.cmd      = tpt_pkg::cmd_t'(cmd);
    item.slot     = slot;
    item.idx      = idx;
    item.offset   = virt_addr[tpt_pkg::PAGE_BITS-1:0];
    item.frame    = phys_addr[31:tpt_pkg::PAGE_BITS];
    item.flags    = page_flags;
    item.slot_oob = ({1'b0, slot} >= DIR_LIM);
    item.idx_oob  = ({1'b0, idx} >= TBL_LIM);
  end

endmodule

`default_nettype wire

/* hdl/tpt_back.sv */
// back end: directory and table memories with the command sequencer
`default_nettype none

module tpt_back #(
  parameter int DIR_ENTRIES   = tpt_pkg::DIR_ENTRIES_DEF,
  parameter int TABLE_ENTRIES = tpt_pkg::TABLE_ENTRIES_DEF,
  parameter int TABLE_POOL    = tpt_pkg::TABLE_POOL_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tpt_pkg::item_t  in_item,
  input  wire logic            in_empty,
  output logic                 in_pop,
  input  wire logic            out_full,
  output logic                 out_push,
  output tpt_pkg::result_t     res,
  output logic                 init_busy
);

  localparam int DIR_AW   = $clog2(DIR_ENTRIES);
  localparam int TABLE_AW = $clog2(TABLE_ENTRIES);
  localparam int POOL_W   = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int USED_W   = $clog2(TABLE_POOL + 1);
  localparam int MEM_DEPTH = TABLE_POOL * TABLE_ENTRIES;
  localparam int MEM_AW   = $clog2(MEM_DEPTH);
  localparam int MAXN     = (DIR_ENTRIES > TABLE_ENTRIES) ? DIR_ENTRIES : TABLE_ENTRIES;
  localparam int CW       = $clog2(MAXN);

  localparam logic [MEM_AW-1:0] TE_M      = MEM_AW'(TABLE_ENTRIES);
  localparam logic [CW:0]       DIR_LIM   = (CW + 1)'(DIR_ENTRIES);
  localparam logic [CW:0]       TBL_LIM   = (CW + 1)'(TABLE_ENTRIES);
  localparam logic [CW-1:0]     INIT_LAST = CW'(MAXN - 1);
  localparam logic [CW-1:0]     CLR_LAST  = CW'(TABLE_ENTRIES - 1);
  localparam logic [USED_W-1:0] POOL_LIM  = USED_W'(TABLE_POOL);

  tpt_pkg::state_t state;
  tpt_pkg::state_t state_next;
  tpt_pkg::item_t  cur;
  tpt_pkg::item_t  cur_next;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_next;
  logic [USED_W-1:0] used;
  logic [USED_W-1:0] used_next;
  logic [POOL_W-1:0] tbl_num;
  logic [POOL_W-1:0] tbl_next;

  // directory: present bit over table number
  logic [POOL_W:0]   dir_mem [DIR_ENTRIES];
  logic [DIR_AW-1:0] dir_addr;
  logic              dir_we;
  logic [POOL_W:0]   dir_wdata;
  logic [POOL_W:0]   dir_rdata;

  // second-level table words of the whole pool
  logic [31:0]       tbl_mem [MEM_DEPTH];
  logic [MEM_AW-1:0] tbl_addr;
  logic              tbl_we;
  logic [31:0]       tbl_wdata;
  logic [31:0]       tbl_rdata;

  logic              start;
  logic              d_valid;
  logic [POOL_W-1:0] d_tbl;
  logic              hit;
  logic              pool_left;
  logic              alloc;
  logic [31:0]       map_word;

  function automatic logic [MEM_AW-1:0] word_addr(input logic [POOL_W-1:0] t,
                                                   input logic [TABLE_AW-1:0] i);
    return MEM_AW'(t) * TE_M + MEM_AW'(i);
  endfunction

  assign start     = !in_empty && !out_full;
  assign d_valid   = dir_rdata[POOL_W];
  assign d_tbl     = dir_rdata[POOL_W-1:0];
  assign hit       = !cur.slot_oob && !cur.idx_oob && d_valid;
  assign pool_left = (used < POOL_LIM);
  assign alloc     = (cur.cmd == tpt_pkg::CMD_MAP) && !cur.slot_oob && !cur.idx_oob
                     && !d_valid && pool_left;
  assign map_word  = {cur.frame, cur.flags | tpt_pkg::ENTRY_PRESENT};
  assign init_busy = (state == tpt_pkg::ST_INIT);

  // directory memory
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_addr] <= dir_wdata;
    end
    dir_rdata <= dir_mem[dir_addr];
  end

  // table memory
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_addr] <= tbl_wdata;
    end
    tbl_rdata <= tbl_mem[tbl_addr];
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tpt_pkg::ST_INIT;
      cnt     <= '0;
      used    <= USED_W'(1);
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      used    <= used_next;
    end
  end

  // request payload and allocated table number
  always_ff @(posedge clk) begin
    cur     <= cur_next;
    tbl_num <= tbl_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tpt_pkg::ST_INIT: begin
        if (cnt == INIT_LAST) begin
          state_next = tpt_pkg::ST_IDLE;
        end
      end
      tpt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = tpt_pkg::ST_DIR;
        end
      end
      tpt_pkg::ST_DIR: begin
        if (alloc) begin
          state_next = tpt_pkg::ST_CLEAR;
        end else if (cur.cmd == tpt_pkg::CMD_XLATE && hit) begin
          state_next = tpt_pkg::ST_READ;
        end else begin
          state_next = tpt_pkg::ST_IDLE;
        end
      end
      tpt_pkg::ST_CLEAR: begin
        if (cnt == CLR_LAST) begin
          state_next = tpt_pkg::ST_FILL;
        end
      end
      tpt_pkg::ST_FILL: state_next = tpt_pkg::ST_IDLE;
      tpt_pkg::ST_READ: state_next = tpt_pkg::ST_IDLE;
      default:          state_next = tpt_pkg::ST_INIT;
    endcase
  end

  // memory controls, results and counters
  always_comb begin
    in_pop     = 1'b0;
    out_push   = 1'b0;
    res.phys   = '0;
    res.status = tpt_pkg::STAT_DONE;
    dir_we     = 1'b0;
    dir_addr   = cur.slot[DIR_AW-1:0];
    dir_wdata  = '0;
    tbl_we     = 1'b0;
    tbl_addr   = word_addr(d_tbl, cur.idx[TABLE_AW-1:0]);
    tbl_wdata  = '0;
    cur_next   = cur;
    cnt_next   = cnt;
    used_next  = used;
    tbl_next   = tbl_num;
    case (state)
      // reset sweep: clear directory but map slot zero to table zero, identity-fill table zero
      tpt_pkg::ST_INIT: begin
        dir_addr  = cnt[DIR_AW-1:0];
        dir_we    = ({1'b0, cnt} < DIR_LIM);
        dir_wdata = {(cnt == '0), {POOL_W{1'b0}}};
        tbl_addr  = MEM_AW'(cnt[TABLE_AW-1:0]);
        tbl_we    = ({1'b0, cnt} < TBL_LIM);
        tbl_wdata = {tpt_pkg::FRAME_W'(cnt[TABLE_AW-1:0]), tpt_pkg::ENTRY_IDENTITY};
        cnt_next  = cnt + 1'b1;
      end
      // take the next request and look up its directory slot
      tpt_pkg::ST_IDLE: begin
        if (start) begin
          in_pop   = 1'b1;
          cur_next = in_item;
          dir_addr = in_item.slot[DIR_AW-1:0];
        end
      end
      // directory answer: finish, allocate or read the entry
      tpt_pkg::ST_DIR: begin
        case (cur.cmd)
          tpt_pkg::CMD_MAP: begin
            if (cur.slot_oob) begin
              out_push   = 1'b1;
              res.status = tpt_pkg::STAT_NO_TABLE;
            end else if (cur.idx_oob) begin
              out_push   = 1'b1;
              res.status = tpt_pkg::STAT_NOT_MAPPED;
            end else if (!d_valid) begin
              if (pool_left) begin
                dir_we    = 1'b1;
                dir_wdata = {1'b1, used[POOL_W-1:0]};
                tbl_next  = used[POOL_W-1:0];
                used_next = used + 1'b1;
                cnt_next  = '0;
              end else begin
                out_push   = 1'b1;
                res.status = tpt_pkg::STAT_NO_TABLE;
              end
            end else begin
              tbl_we    = 1'b1;
              tbl_wdata = map_word;
              out_push  = 1'b1;
            end
          end
          tpt_pkg::CMD_UNMAP: begin
            out_push = 1'b1;
            if (hit) begin
              tbl_we = 1'b1;
            end else begin
              res.status = tpt_pkg::STAT_NOT_MAPPED;
            end
          end
          tpt_pkg::CMD_XLATE: begin
            if (!hit) begin
              out_push   = 1'b1;
              res.status = tpt_pkg::STAT_NOT_MAPPED;
            end
          end
          default: begin
            out_push = 1'b1;
          end
        endcase
      end
      // zero the freshly allocated table
      tpt_pkg::ST_CLEAR: begin
        tbl_we   = 1'b1;
        tbl_addr = word_addr(tbl_num, cnt[TABLE_AW-1:0]);
        cnt_next = cnt + 1'b1;
      end
      // store the mapping into the new table
      tpt_pkg::ST_FILL: begin
        tbl_we    = 1'b1;
        tbl_addr  = word_addr(tbl_num, cur.idx[TABLE_AW-1:0]);
        tbl_wdata = map_word;
        out_push  = 1'b1;
      end
      // translate answer
      tpt_pkg::ST_READ: begin
        out_push = 1'b1;
        if (tbl_rdata[0]) begin
          res.phys = {tbl_rdata[31:tpt_pkg::PAGE_BITS], cur.offset};
        end else begin
          res.status = tpt_pkg::STAT_NOT_MAPPED;
        end
      end
      default: begin
        cnt_next = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a result is only produced when the result queue has room
  assert property (@(posedge clk) disable iff (rst) out_push |-> !out_full)
    else $error("result pushed into a full queue");

  // pool count stays within the pool
  assert property (@(posedge clk) disable iff (rst)
    (used != '0) && (used <= POOL_LIM))
    else $error("table pool count out of range");

  // allocation takes exactly one pool table
  assert property (@(posedge clk) disable iff (rst)
    (state == tpt_pkg::ST_DIR && state_next == tpt_pkg::ST_CLEAR)
    |=> (used == $past(used) + 1'b1))
    else $error("allocation did not advance the pool count");

  // a table clear always ends by storing the mapping
  assert property (@(posedge clk) disable iff (rst)
    (state == tpt_pkg::ST_CLEAR)
    |=> (state == tpt_pkg::ST_CLEAR || state == tpt_pkg::ST_FILL))
    else $error("table clear left early");

  // no request is taken during the reset sweep
  assert property (@(posedge clk) disable iff (rst) init_busy |-> !in_pop)
    else $error("request taken during reset sweep");
`endif

endmodule

`default_nettype wire

/* hdl/two_level_page_table_engine.sv */
// top level of the two-level page table engine
// Requests (map, unmap, translate) enter through a queue-style port: a request
// is taken on a clock edge with push high and full low. Results leave through a
// second queue-style port: the oldest result is shown while empty is low and
// is consumed on an edge with pop high. Every request gives exactly one result.
// The front end classifies requests into a two-entry queue; the back end runs
// them one at a time against a directory memory and a pooled table memory.
// Unmap, a map to a present slot and no-op requests finish on the registered
// directory answer; a translate then reads the table entry, and a map that
// allocates a table first clears the new table one word per cycle through
// the single table memory port, then stores the mapping. The back end takes
// no new request until the current one has given its result.
// After rst the back end sweeps the memories, clearing the directory and
// identity-mapping table zero under slot zero; full stays high meanwhile.
// If the receiver stops popping, results collect in a two-entry queue, then
// the back end halts and the request queue fills, raising full.
`default_nettype none

module two_level_page_table_engine #(
  parameter int DIR_ENTRIES   = tpt_pkg::DIR_ENTRIES_DEF,
  parameter int TABLE_ENTRIES = tpt_pkg::TABLE_ENTRIES_DEF,
  parameter int TABLE_POOL    = tpt_pkg::TABLE_POOL_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] virt_addr,
  input  wire logic [31:0] phys_addr,
  input  wire logic [11:0] page_flags,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      phys_out,
  output logic [1:0]       status
);

  localparam int ITEM_W = $bits(tpt_pkg::item_t);
  localparam int RES_W  = $bits(tpt_pkg::result_t);

  tpt_pkg::item_t   front_item;
  tpt_pkg::item_t   queue_item;
  tpt_pkg::result_t back_res;
  tpt_pkg::result_t res_head;
  logic             cmdq_full;
  logic             cmdq_empty;
  logic             cmdq_pop;
  logic             resq_full;
  logic             res_push;
  logic             init_busy;

  assign full     = cmdq_full || init_busy;
  assign phys_out = res_head.phys;
  assign status   = res_head.status;

  // request classification
  tpt_front #(
    .DIR_ENTRIES   (DIR_ENTRIES),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .cmd        (cmd),
    .virt_addr  (virt_addr),
    .phys_addr  (phys_addr),
    .page_flags (page_flags),
    .item       (front_item)
  );

  // queue between front and back
  tpt_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (tpt_pkg::QUEUE_DEPTH_DEF)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_data (front_item),
    .full    (cmdq_full),
    .rd_en   (cmdq_pop),
    .rd_data (queue_item),
    .empty   (cmdq_empty)
  );

  // page table sequencer
  tpt_back #(
    .DIR_ENTRIES   (DIR_ENTRIES),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TABLE_POOL    (TABLE_POOL)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_item   (queue_item),
    .in_empty  (cmdq_empty),
    .in_pop    (cmdq_pop),
    .out_full  (resq_full),
    .out_push  (res_push),
    .res       (back_res),
    .init_busy (init_busy)
  );

  // result queue toward the receiver
  tpt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (tpt_pkg::QUEUE_DEPTH_DEF)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (back_res),
    .full    (resq_full),
    .rd_en   (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

endmodule

`default_nettype wire
